// File: hdl/erl_pkg.sv
// erl_pkg: shared types and constants for the event log ring store.
// Used by erl_cell and event_log_ring_store; depends on nothing.
`default_nettype none
package erl_pkg;

  localparam int LOG_DEPTH = 16;
  localparam int AW        = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W     = $clog2(LOG_DEPTH + 1);
  localparam int ID_W      = 16;

  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_FIND   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] stamp_ms;
    logic [7:0]  module_no;
    logic [7:0]  subsystem_no;
    logic [7:0]  error_code;
    logic [2:0]  severity_level;
    logic [7:0]  payload_len;
    logic [15:0] position;
    logic [15:0] wanted_id;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [15:0]      seq_id;
    logic [31:0]      entry_stamp_ms;
    logic [7:0]       entry_module;
    logic [7:0]       entry_subsystem;
    logic [7:0]       entry_code;
    logic [2:0]       entry_severity;
    logic [7:0]       entry_payload_len;
    logic [4:0]       stored_count;
  } out_item_t;

  // one stored log entry
  typedef struct packed {
    logic [ID_W-1:0] seq_id;
    logic [31:0]     stamp_ms;
    logic [7:0]      module_no;
    logic [7:0]      subsystem_no;
    logic [7:0]      error_code;
    logic [2:0]      severity;
    logic [7:0]      payload_len;
  } log_entry_t;

  // request travelling down the cell chain
  typedef struct packed {
    logic             active;
    logic [1:0]       op;
    logic [AW-1:0]    slot;
    logic [ID_W-1:0]  want;
    logic [CNT_W-1:0] count;
    logic             hit;
    log_entry_t       entry;
  } probe_t;

endpackage
`default_nettype wire

// File: hdl/event_log_ring_store.sv
// event_log_ring_store: circular error-event log built as a chain of slot cells.
// Depends on erl_pkg and erl_cell.
`default_nettype none
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------
// in      | input     | in_valid / in_stall  | in_item_t
// out     | output    | out_valid / out_stall| out_item_t
//
// Each item enters cell 0 at its accepting edge and moves one cell per cycle,
// unless the chain is frozen, through LOG_DEPTH cells, then lands in the output
// register, where out_valid rises. in_stall drops at that same edge, so the next
// item is accepted only after the previous one has reached the output register.
// Synchronous active-low reset clears pointer, count and chain control, and sets the id counter to 1.
// A stalled output freezes the chain; in_stall is high while an item is in flight.
module event_log_ring_store
  import erl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  // ring control state
  logic [AW-1:0]    wslot_r, wslot_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [ID_W-1:0]  seq_r, seq_nxt;
  logic             busy_r, busy_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;

  logic             accept;
  logic             adv;
  logic             out_load;
  logic [AW:0]      rd_sum;
  logic [AW-1:0]    rd_slot;
  probe_t           inj;
  probe_t           chain [LOG_DEPTH+1];
  probe_t           last;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;

  // slot of the entry pos places back from the newest, modulo LOG_DEPTH;
  // only used when pos < count, so pos fits the slot index
  always_comb begin
    rd_sum = {1'b0, wslot_r} + (AW+1)'(LOG_DEPTH - 1)
             - {1'b0, in_item.position[AW-1:0]};
    if (rd_sum >= (AW+1)'(LOG_DEPTH)) begin
      rd_sum = rd_sum - (AW+1)'(LOG_DEPTH);
    end
    rd_slot = rd_sum[AW-1:0];
  end

  // build the request and the next control state
  always_comb begin
    wslot_nxt = wslot_r;
    count_nxt = count_r;
    seq_nxt   = seq_r;
    inj        = '0;
    inj.active = accept;
    inj.op     = in_item.action;
    inj.want   = in_item.wanted_id;
    if (accept) begin
      case (in_item.action)
        ACT_RECORD: begin
          inj.slot                 = wslot_r;
          inj.hit                  = 1'b1;
          inj.entry.seq_id         = seq_r;
          inj.entry.stamp_ms       = in_item.stamp_ms;
          inj.entry.module_no      = in_item.module_no;
          inj.entry.subsystem_no   = in_item.subsystem_no;
          inj.entry.error_code     = in_item.error_code;
          inj.entry.severity       = in_item.severity_level;
          inj.entry.payload_len    = in_item.payload_len;
          seq_nxt   = seq_r + 1'b1;
          wslot_nxt = (wslot_r == AW'(LOG_DEPTH - 1)) ? '0 : wslot_r + 1'b1;
          if (count_r < CNT_W'(LOG_DEPTH)) count_nxt = count_r + 1'b1;
        end
        ACT_READ: begin
          inj.slot = rd_slot;
          // out of range: travel as a no-op so found and the entry fields stay zero
          if (in_item.position >= 16'(count_r)) inj.op = ACT_CLEAR;
        end
        ACT_FIND: ;
        ACT_CLEAR: begin
          wslot_nxt = '0;
          count_nxt = '0;
          seq_nxt   = ID_W'(1);
        end
        default: ;
      endcase
    end
    inj.count = count_nxt;
  end

  assign chain[0] = inj;

  for (genvar i = 0; i < LOG_DEPTH; i++) begin : g_cell
    erl_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (AW'(i)),
      .p_in     (chain[i]),
      .p_out    (chain[i+1])
    );
  end

  assign last     = chain[LOG_DEPTH];
  assign out_load = last.active && (!out_valid_r || !out_stall);
  assign adv      = !last.active || out_load;

  always_comb begin
    busy_nxt = busy_r;
    if (accept)        busy_nxt = 1'b1;
    else if (out_load) busy_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wslot_r     <= '0;
      count_r     <= '0;
      seq_r       <= ID_W'(1);
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wslot_r     <= wslot_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.found             <= last.hit;
      out_item_r.seq_id            <= last.entry.seq_id;
      out_item_r.entry_stamp_ms    <= last.entry.stamp_ms;
      out_item_r.entry_module      <= last.entry.module_no;
      out_item_r.entry_subsystem   <= last.entry.subsystem_no;
      out_item_r.entry_code        <= last.entry.error_code;
      out_item_r.entry_severity    <= last.entry.severity;
      out_item_r.entry_payload_len <= last.entry.payload_len;
      out_item_r.stored_count      <= 5'(last.count);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: hdl/erl_cell.sv
// erl_cell: one log slot plus one stage of the request chain.
// Depends on erl_pkg.
`default_nettype none
module erl_cell
  import erl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire logic [AW-1:0] cell_idx,
  input  wire probe_t  p_in,
  output probe_t       p_out
);

  probe_t     p_r, p_nxt;
  log_entry_t ent_r;
  logic       wr;

  always_comb begin
    p_nxt = p_in;
    wr    = 1'b0;
    if (p_in.active) begin
      case (p_in.op)
        ACT_RECORD: begin
          if (cell_idx == p_in.slot) wr = 1'b1;
        end
        ACT_READ: begin
          if (cell_idx == p_in.slot) begin
            p_nxt.hit   = 1'b1;
            p_nxt.entry = ent_r;
          end
        end
        ACT_FIND: begin
          // first valid slot with a matching id wins
          if (!p_in.hit && (CNT_W'(cell_idx) < p_in.count) &&
              (ent_r.seq_id == p_in.want)) begin
            p_nxt.hit   = 1'b1;
            p_nxt.entry = ent_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
    end else if (adv) begin
      p_r <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr) begin
      ent_r <= p_in.entry;
    end
  end

  assign p_out = p_r;

endmodule
`default_nettype wire

// File: dv/event_log_ring_store_tb.sv
// event_log_ring_store_tb: self-checking bench for the circular event log.
// Drives record/read/find/clear items, predicts every result, checks field by field.
// Depends on erl_pkg and the event_log_ring_store RTL.
module event_log_ring_store_tb;
  import erl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Bench knobs
  localparam int unsigned RUN_LIMIT    = 200_000;    // cycles, well over the slowest run
  localparam int unsigned LONG_HOLD    = 300;        // receiver hold-off, cycles
  localparam int unsigned SETTLE       = 4 * (LOG_DEPTH + 2);
  localparam int unsigned PRINT_MAX    = 40;
  localparam int unsigned PHASE_ITEMS  = 500;

  // Clock and reset
  logic clk;
  logic rst_n = 1'b0;

  always begin
    clk = 1'b0;
    #5ns;
    clk = 1'b1;
    #5ns;
  end

  // DUT ports
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  event_log_ring_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Item queues: what is still to be offered, and what the log should answer
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 52;
  int unsigned error_count   = 0;
  int unsigned result_no     = 0;
  int unsigned cycle_count   = 0;

  // Receiver long hold-off, counted down in its own process
  logic        long_hold_kick = 1'b0;
  int unsigned long_hold_left = 0;

  // Shadow of the ring, used to predict results
  log_entry_t  ring_entries [LOG_DEPTH];
  int          ring_wr_slot;
  int          ring_count;
  logic [15:0] ring_next_id;

  // Steering state for the generator: count and id as of the last queued item
  int          gen_count;
  logic [15:0] gen_next_id;

  //--------------------------------------------------------------------------
  // Predictor
  //--------------------------------------------------------------------------
  function automatic out_item_t log_predict(in_item_t it);
    out_item_t  res;
    log_entry_t e;
    int         hit_slot;
    res      = '0;
    hit_slot = -1;
    case (it.action)
      ACT_RECORD: begin
        e.seq_id       = ring_next_id;
        e.stamp_ms     = it.stamp_ms;
        e.module_no    = it.module_no;
        e.subsystem_no = it.subsystem_no;
        e.error_code   = it.error_code;
        e.severity     = it.severity_level;
        e.payload_len  = it.payload_len;
        ring_entries[ring_wr_slot] = e;
        hit_slot     = ring_wr_slot;
        ring_wr_slot = (ring_wr_slot + 1) % LOG_DEPTH;
        ring_next_id = ring_next_id + 16'd1;   // wraps to 0 after 65535
        if (ring_count < LOG_DEPTH) ring_count++;
      end
      ACT_READ: begin
        // position 0 is the newest entry, i.e. the slot just behind the write pointer
        if (int'(it.position) < ring_count)
          hit_slot = (ring_wr_slot + LOG_DEPTH - 1 - int'(it.position)) % LOG_DEPTH;
      end
      ACT_FIND: begin
        // lowest slot wins; only the valid slots are searched, never stale ones
        for (int i = 0; i < ring_count && hit_slot < 0; i++)
          if (ring_entries[i].seq_id == it.wanted_id) hit_slot = i;
      end
      ACT_CLEAR: begin
        ring_wr_slot = 0;
        ring_count   = 0;
        ring_next_id = 16'd1;
      end
      default: ;
    endcase
    if (hit_slot >= 0) begin
      e                     = ring_entries[hit_slot];
      res.found             = 1'b1;
      res.seq_id            = e.seq_id;
      res.entry_stamp_ms    = e.stamp_ms;
      res.entry_module      = e.module_no;
      res.entry_subsystem   = e.subsystem_no;
      res.entry_code        = e.error_code;
      res.entry_severity    = e.severity;
      res.entry_payload_len = e.payload_len;
    end
    res.stored_count = 5'(ring_count);
    return res;
  endfunction

  //--------------------------------------------------------------------------
  // Checking
  //--------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < PRINT_MAX)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, result_no, what, got, want);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(name, got, want);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected, seq_id", 32'(got.seq_id), '0);
    end else begin
      want = expected_results.pop_front();
      check_field("found",             32'(got.found),             32'(want.found));
      check_field("seq_id",            32'(got.seq_id),            32'(want.seq_id));
      check_field("entry_stamp_ms",    32'(got.entry_stamp_ms),    32'(want.entry_stamp_ms));
      check_field("entry_module",      32'(got.entry_module),      32'(want.entry_module));
      check_field("entry_subsystem",   32'(got.entry_subsystem),   32'(want.entry_subsystem));
      check_field("entry_code",        32'(got.entry_code),        32'(want.entry_code));
      check_field("entry_severity",    32'(got.entry_severity),    32'(want.entry_severity));
      check_field("entry_payload_len", 32'(got.entry_payload_len), 32'(want.entry_payload_len));
      check_field("stored_count",      32'(got.stored_count),      32'(want.stored_count));
    end
    result_no++;
  endtask

  //--------------------------------------------------------------------------
  // Driver: offers queued items; an offered item holds until accepted.
  // Prediction happens at the accepting edge so the shadow tracks the DUT order.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(log_predict(in_item));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks accepted results, drives random and long receiver stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      out_stall <= (long_hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      long_hold_left <= 0;
    end else if (long_hold_left != 0) begin
      long_hold_left <= long_hold_left - 1;
    end else if (long_hold_kick) begin
      long_hold_left <= LONG_HOLD;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog
  initial begin
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected",
             cycle_count, expected_results.size());
    $display("Some tests failed");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Stimulus helpers
  //--------------------------------------------------------------------------
  // Fields an action does not use still carry random noise.
  function automatic in_item_t noise_item(logic [1:0] act);
    in_item_t it;
    it.action         = act;
    it.stamp_ms       = $urandom();
    it.module_no      = 8'($urandom());
    it.subsystem_no   = 8'($urandom());
    it.error_code     = 8'($urandom());
    it.severity_level = 3'($urandom());
    it.payload_len    = 8'($urandom());
    it.position       = 16'($urandom());
    it.wanted_id      = 16'($urandom());
    return it;
  endfunction

  function automatic in_item_t read_item(logic [15:0] pos);
    in_item_t it;
    it          = noise_item(ACT_READ);
    it.position = pos;
    return it;
  endfunction

  function automatic in_item_t find_item(logic [15:0] id);
    in_item_t it;
    it           = noise_item(ACT_FIND);
    it.wanted_id = id;
    return it;
  endfunction

  // Keeps the generator's idea of count and next id in step with the queue
  task automatic queue_item(in_item_t it);
    pending_items.push_back(it);
    case (it.action)
      ACT_RECORD: begin
        gen_next_id = gen_next_id + 16'd1;
        if (gen_count < LOG_DEPTH) gen_count++;
      end
      ACT_CLEAR: begin
        gen_count   = 0;
        gen_next_id = 16'd1;
      end
      default: ;
    endcase
  endtask

  // Mostly records/reads/finds aimed at live entries; clears rare so the log fills up
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      it = noise_item(ACT_RECORD);
    else if (pick < 70) it = noise_item(ACT_READ);
    else if (pick < 98) it = noise_item(ACT_FIND);
    else                it = noise_item(ACT_CLEAR);
    if ($urandom_range(9) < 8)
      it.position = 16'($urandom_range(gen_count + 1, 0));
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5:
        // recent ids: some live, some just overwritten
        it.wanted_id = gen_next_id - 16'd1 - 16'($urandom_range(LOG_DEPTH + 1, 0));
      8:       it.wanted_id = 16'h0000;
      9:       it.wanted_id = 16'hFFFF;
      default: ;
    endcase
    return it;
  endfunction

  // Sender pause: nothing offered until every expected result is back.
  // Sampled between edges so the driver's and monitor's updates have settled.
  task automatic wait_log_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  //--------------------------------------------------------------------------
  // Test sequence
  //--------------------------------------------------------------------------
  initial begin
    in_item_t it;
    ring_wr_slot = 0;
    ring_count   = 0;
    ring_next_id = 16'd1;
    gen_count    = 0;
    gen_next_id  = 16'd1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty log, field extremes, read/find hits and misses
    queue_item(read_item(16'd0));              // read from an empty log
    queue_item(find_item(16'd1));              // find in an empty log
    it = noise_item(ACT_RECORD);               // all fields at max
    it.stamp_ms       = '1;
    it.module_no      = '1;
    it.subsystem_no   = '1;
    it.error_code     = '1;
    it.severity_level = '1;
    it.payload_len    = '1;
    queue_item(it);
    it = noise_item(ACT_RECORD);               // all fields at zero
    it.stamp_ms       = '0;
    it.module_no      = '0;
    it.subsystem_no   = '0;
    it.error_code     = '0;
    it.severity_level = '0;
    it.payload_len    = '0;
    queue_item(it);
    queue_item(read_item(16'd0));              // newest
    queue_item(read_item(16'd1));              // oldest
    queue_item(read_item(16'd2));              // position == count: miss
    queue_item(read_item(16'hFFFF));
    queue_item(find_item(16'd1));
    queue_item(find_item(16'd2));
    queue_item(find_item(16'd0));
    queue_item(find_item(16'hFFFF));
    // stale slots after a clear must stay invisible to read and find
    queue_item(noise_item(ACT_CLEAR));
    repeat (3) queue_item(noise_item(ACT_RECORD));
    queue_item(noise_item(ACT_CLEAR));
    queue_item(noise_item(ACT_RECORD));        // id restarts at 1
    queue_item(find_item(16'd3));              // id 3 only in a stale slot
    queue_item(read_item(16'd1));
    queue_item(find_item(16'd1));
    queue_item(read_item(16'd0));
    wait_log_idle();

    // Phase 1: sender idles 26%, receiver 52%, with one long receiver hold-off
    repeat (PHASE_ITEMS / 2) queue_item(random_item());
    long_hold_kick <= 1'b1;
    @(posedge clk);
    long_hold_kick <= 1'b0;
    repeat (PHASE_ITEMS / 2) queue_item(random_item());
    wait_log_idle();

    // Phase 2: roles swapped
    send_idle_pct <= 52;
    recv_idle_pct <= 26;
    repeat (PHASE_ITEMS) queue_item(random_item());
    wait_log_idle();

    // Phase 3: back to back
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    repeat (PHASE_ITEMS) queue_item(random_item());
    wait_log_idle();

    // Settle: give any stray result time to come out of the chain
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/erl_pkg.sv
hdl/erl_cell.sv
hdl/event_log_ring_store.sv
dv/event_log_ring_store_tb.sv
